/* design/can_bit_timing_solver_top_macros.svh */
// Assertion macros for the CAN bit timing solver.
`ifndef CAN_BIT_TIMING_SOLVER_TOP_MACROS_SVH
`define CAN_BIT_TIMING_SOLVER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define CBTS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define CBTS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/cbts_pkg.sv */
// Types and constants shared by the CAN bit timing solver modules.
package cbts_pkg;

  localparam int unsigned DIV_W = 30;
  localparam int unsigned CNT_W = $clog2(DIV_W + 1);
  localparam int unsigned PB_W  = 21;   // clock / bitrate with bitrate >= 1000
  localparam int unsigned SUM_W = 5;

  localparam logic [DIV_W-1:0] MIN_BITRATE  = DIV_W'(1000);
  localparam logic [DIV_W-1:0] FAST_BITRATE = DIV_W'(1000000);
  localparam int unsigned FAST_MAX_Q = 10;
  localparam int unsigned SLOW_MAX_Q = 17;
  localparam int unsigned PRESC_MAX  = 256;
  localparam int unsigned SP_SCALE   = 1000;
  localparam int unsigned SP_LIMIT   = 900;

  localparam logic [DIV_W-1:0] CLK_HZ_RESET = DIV_W'(24000000);
  localparam logic [7:0] PRESC_RESET = 8'd29;
  localparam logic [1:0] SJW_RESET   = 2'd3;
  localparam logic [3:0] SEG1_RESET  = 4'd15;
  localparam logic [2:0] SEG2_RESET  = 3'd2;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

/* design/can_bit_timing_solver_top.sv */
// Flow: a rejected bitrate (below 1000, or a quanta count beyond MAX_SEG1 + MAX_SEG2) goes
// straight to the result; otherwise one division for clock/bitrate, one per quanta count tried
// (up to 15) and one for the final rate check. A new bitrate is taken only once the last is through;
// the shared 30-bit serial divider does every division.
// Reset: asynchronous, active low; clock register 24000000, held timing 29/3/15/2.
// A result waiting on the output does not block the next input beat.
module can_bit_timing_solver_top import cbts_pkg::*; #(
  parameter int unsigned MAX_SEG1 = 16,
  parameter int unsigned MAX_SEG2 = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [DIV_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [DIV_W-1:0] bitrate_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             ok_o,
  output logic [7:0]       prescaler_field_o,
  output logic [1:0]       jump_width_field_o,
  output logic [3:0]       seg1_field_o,
  output logic [2:0]       seg2_field_o
);

  `include "can_bit_timing_solver_top_macros.svh"

  localparam int unsigned SEG_SUM = MAX_SEG1 + MAX_SEG2;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIV_PB = 6'b000010,
    S_MOD    = 6'b000100,
    S_CHECK  = 6'b001000,
    S_DIV_RT = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q;

  logic [DIV_W-1:0] clk_hz_q;
  logic [DIV_W-1:0] rate_q;
  logic [PB_W-1:0]  per_bit_q;
  logic [PB_W-1:0]  presc_q;
  logic [SUM_W-1:0] sum_q;
  logic [3:0]       seg1_q;
  logic [2:0]       seg2_q;
  logic             pass_q;
  logic             out_valid_q;
  logic             ok_q;
  logic [7:0]       held_presc_q;
  logic [1:0]       held_sjw_q;
  logic [3:0]       held_seg1_q;
  logic [2:0]       held_seg2_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_acc;
  logic in_fast;
  logic in_reject;
  logic out_free;

  assign in_acc   = in_valid_i && in_ready_o;
  assign in_fast  = bitrate_i >= FAST_BITRATE;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    in_reject = bitrate_i < MIN_BITRATE;
    if (in_fast) begin
      if (FAST_MAX_Q > SEG_SUM) in_reject = 1'b1;
    end else begin
      if (SLOW_MAX_Q > SEG_SUM) in_reject = 1'b1;
    end
  end

  // Segment split for the current quanta count (sum = quanta - 1).
  logic [6:0]       s1n_t, s1d_t;
  logic [3:0]       s1n, s1d, s1;
  logic [SUM_W-1:0] s2;
  logic [14:0]      sp_lhs, sp_rhs;
  logic             sp_high;
  logic             chk_ok;

  always_comb begin
    s1n_t   = 7'd7 * {2'b0, sum_q} + 7'd3;   // round to nearest 87.5%
    s1d_t   = 7'd7 * {2'b0, sum_q} - 7'd1;   // round down
    s1n     = s1n_t[6:3];
    s1d     = s1d_t[6:3];
    // floor(1000*(1+s1)/(1+sum)) > 900 <=> 1000*(1+s1) >= 901*(1+sum)
    sp_lhs  = 15'(SP_SCALE) * (15'd1 + {11'b0, s1n});
    sp_rhs  = 15'(SP_LIMIT + 1) * (15'd1 + {10'b0, sum_q});
    sp_high = sp_lhs >= sp_rhs;
    s1      = sp_high ? s1d : s1n;
    s2      = sum_q - {1'b0, s1};
    chk_ok  = (sum_q > {1'b0, s1n})
           && (presc_q != '0) && (presc_q <= PB_W'(PRESC_MAX))
           && (s1 != '0) && (32'(s1) <= MAX_SEG1)
           && (s2 != '0) && (32'(s2) <= MAX_SEG2);
  end

  always_comb begin
    div_req = '0;
    unique case (state_q)
      S_IDLE: begin
        div_req.start    = in_acc && !in_reject;
        div_req.dividend = clk_hz_q;
        div_req.divisor  = bitrate_i;
      end
      S_DIV_PB: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = DIV_W'(div_rsp.quot[PB_W-1:0]);
        div_req.divisor  = DIV_W'(sum_q) + DIV_W'(1);
      end
      S_MOD: begin
        // retry with one quanta fewer: divisor is the old sum
        div_req.start    = div_rsp.done && (div_rsp.rem != '0) && (sum_q > SUM_W'(2));
        div_req.dividend = DIV_W'(per_bit_q);
        div_req.divisor  = DIV_W'(sum_q);
      end
      S_CHECK: begin
        div_req.start    = chk_ok;
        div_req.dividend = clk_hz_q;
        div_req.divisor  = DIV_W'(per_bit_q);
      end
      S_DIV_RT, S_DONE: begin
        div_req = '0;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  cbts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      clk_hz_q     <= CLK_HZ_RESET;
      out_valid_q  <= 1'b0;
      ok_q         <= 1'b0;
      pass_q       <= 1'b0;
      held_presc_q <= PRESC_RESET;
      held_sjw_q   <= SJW_RESET;
      held_seg1_q  <= SEG1_RESET;
      held_seg2_q  <= SEG2_RESET;
    end else begin
      if (cfg_we_i) clk_hz_q <= cfg_wdata_i;
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            pass_q  <= 1'b0;
            state_q <= in_reject ? S_DONE : S_DIV_PB;
          end
        end
        S_DIV_PB: begin
          if (div_rsp.done) state_q <= S_MOD;
        end
        S_MOD: begin
          if (div_rsp.done) begin
            if (div_rsp.rem == '0) begin
              state_q <= S_CHECK;
            end else if (sum_q <= SUM_W'(2)) begin
              state_q <= S_DONE;
            end
          end
        end
        S_CHECK: begin
          state_q <= chk_ok ? S_DIV_RT : S_DONE;
        end
        S_DIV_RT: begin
          if (div_rsp.done) begin
            pass_q  <= div_rsp.quot == rate_q;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            ok_q <= pass_q;
            if (pass_q) begin
              held_presc_q <= 8'(presc_q - PB_W'(1));
              held_sjw_q   <= '0;
              held_seg1_q  <= seg1_q;
              held_seg2_q  <= seg2_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_acc) begin
      rate_q <= bitrate_i;
      sum_q  <= in_fast ? SUM_W'(FAST_MAX_Q - 1) : SUM_W'(SLOW_MAX_Q - 1);
    end
    if (state_q == S_DIV_PB && div_rsp.done) per_bit_q <= div_rsp.quot[PB_W-1:0];
    if (state_q == S_MOD && div_rsp.done) begin
      if (div_rsp.rem == '0) presc_q <= div_rsp.quot[PB_W-1:0];
      else sum_q <= sum_q - 1'b1;
    end
    if (state_q == S_CHECK) begin
      seg1_q <= s1 - 4'd1;
      seg2_q <= 3'(s2 - SUM_W'(1));
    end
  end

  assign in_ready_o         = state_q == S_IDLE;
  assign out_valid_o        = out_valid_q;
  assign ok_o               = ok_q;
  assign prescaler_field_o  = held_presc_q;
  assign jump_width_field_o = held_sjw_q;
  assign seg1_field_o       = held_seg1_q;
  assign seg2_field_o       = held_seg2_q;

  `CBTS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  `CBTS_ASSERT_NOW(a_ok_sjw_zero, out_valid_o && ok_o, jump_width_field_o == 2'd0, "sjw not zero")
  `CBTS_ASSERT_NOW(a_ok_seg_limits, out_valid_o && ok_o,
    (32'(seg1_field_o) < MAX_SEG1) && (32'(seg2_field_o) < MAX_SEG2), "segment out of range")

endmodule

/* design/cbts_div.sv */
// Restoring divider, one quotient bit per cycle.
module cbts_div import cbts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quot_q, quot_d;
  logic [DIV_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DIV_W:0] shifted;
  logic [DIV_W:0] diff;
  logic           ge;

  always_comb begin
    shifted = {rem_q, quot_q[DIV_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = shifted >= {1'b0, dvs_q};
    rem_d   = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    quot_d  = {quot_q[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !req_i.start && busy_q && (cnt_q == CNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      quot_q <= req_i.dividend;
      dvs_q  <= req_i.divisor;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule
